/* hdl/hex_base64_text_encoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// hex_base64_text_encoder_unit_defines
// Assertion macros shared by the encoder's checker.
// ----------------------------------------------------------------------------
`ifndef HEX_BASE64_TEXT_ENCODER_UNIT_DEFINES_SVH
`define HEX_BASE64_TEXT_ENCODER_UNIT_DEFINES_SVH

// Implication checked on the same edge, suspended while in reset.
`define HBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the next edge, suspended while in reset.
`define HBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked on the next edge, live during reset as well.
`define HBE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hbe_pkg.sv */
// ----------------------------------------------------------------------------
// hbe_pkg
// Types, codes and character tables of the hex / base64 text encoder.
// ----------------------------------------------------------------------------
package hbe_pkg;

    // encoding_mode register codes; the unused code acts as pass-through
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_HEX   = 2'd1;
    localparam logic [1:0] MODE_B64   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='

    localparam int QUEUE_DEPTH_DEF = 2;

    // One decoded byte: up to four characters, index of the final one,
    // and whether the final one closes the text.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'b0000, d};
        else
            r = 8'h57 + {4'b0000, d};
        return r;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h47 + {2'b00, v};        // 'a' - 26
        else if (v < 6'd62)
            r = {2'b00, v} - 8'd4;          // '0' + (v - 52)
        else if (v == 6'd62)
            r = 8'h2B;                      // '+'
        else
            r = 8'h2F;                      // '/'
        return r;
    endfunction

endpackage

/* hdl/hex_base64_text_encoder_unit.sv */
// ----------------------------------------------------------------------------
// hex_base64_text_encoder_unit
// Byte stream to text: pass-through, lowercase hex, or padded base64.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Word                          Accept
//  s_axis    in    tdata[7:0]=in_byte, tlast     tvalid & tready
//  m_axis    out   tdata[7:0]=out_char, tlast    tvalid & tready
//  cfg       in    cfg_wdata[1:0]=encoding_mode  cfg_we
//
//  Output runs at one character per cycle from the back end while m_axis_tready
//  is high. A byte yields one character in pass-through, two in hex and one to
//  four in base64; the input side keeps pace as long as the job queue
//  (QUEUE_DEPTH entries) has room. Reset clears the group state, the queue and
//  the output valid flag; encoding_mode resets to pass-through. A stalled
//  m_axis holds its word and fills the queue before s_axis_tready drops.
//
module hex_base64_text_encoder_unit
#(
    parameter int QUEUE_DEPTH = hbe_pkg::QUEUE_DEPTH_DEF   // 2 .. 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,    // last_byte
    // output characters
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_char
    output logic       m_axis_tlast,    // last_char
    // encoding_mode register: the user must write it only while idle, unchecked by the block
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    logic [1:0]    mode_reg;
    logic [1:0]    mode_next;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    hbe_pkg::job_t push_job;
    hbe_pkg::job_t pop_job;

    assign mode_next = cfg_we ? cfg_wdata : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= hbe_pkg::MODE_PASS;
        else
            mode_reg <= mode_next;
    end

    // front: classify the byte and build its character job
    hbe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // jobs waiting between front and back
    hbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back: one character per cycle into the output register while the output is not stalled
    hbe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_job     (pop_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

/* hdl/hbe_front.sv */
// ----------------------------------------------------------------------------
// hbe_front
// Accepts bytes, tracks the base64 group, and turns each byte into a job.
// ----------------------------------------------------------------------------
module hbe_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output hbe_pkg::job_t     q_job
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [3:0] held_reg;
    logic [3:0] held_next;
    hbe_pkg::job_t job;
    logic [1:0] pos_upd;
    logic [3:0] held_upd;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_job    = job;

    always_comb
    begin
        job.chars    = '0;
        job.last_idx = 2'd0;
        job.last     = in_last;
        pos_upd      = 2'd0;
        held_upd     = 4'd0;
        unique case (mode)
            hbe_pkg::MODE_B64:
            begin
                case (pos_reg)
                    2'd1:
                    begin
                        job.chars[0] = hbe_pkg::b64_char({held_reg[1:0], in_byte[7:4]});
                        job.chars[1] = hbe_pkg::b64_char({in_byte[3:0], 2'b00});
                        job.chars[2] = hbe_pkg::CHAR_PAD;
                        job.last_idx = in_last ? 2'd2 : 2'd0;
                        pos_upd      = 2'd2;
                        held_upd     = in_byte[3:0];
                    end
                    2'd2:
                    begin
                        job.chars[0] = hbe_pkg::b64_char({held_reg, in_byte[7:6]});
                        job.chars[1] = hbe_pkg::b64_char(in_byte[5:0]);
                        job.last_idx = 2'd1;
                    end
                    default:
                    begin
                        // group start (position three never occurs, read as start)
                        job.chars[0] = hbe_pkg::b64_char(in_byte[7:2]);
                        job.chars[1] = hbe_pkg::b64_char({in_byte[1:0], 4'b0000});
                        job.chars[2] = hbe_pkg::CHAR_PAD;
                        job.chars[3] = hbe_pkg::CHAR_PAD;
                        job.last_idx = in_last ? 2'd3 : 2'd0;
                        pos_upd      = 2'd1;
                        held_upd     = {2'b00, in_byte[1:0]};
                    end
                endcase
            end
            hbe_pkg::MODE_HEX:
            begin
                job.chars[0] = hbe_pkg::hex_char(in_byte[7:4]);
                job.chars[1] = hbe_pkg::hex_char(in_byte[3:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                job.chars[0] = in_byte;
            end
        endcase
    end

    always_comb
    begin
        pos_next  = pos_reg;
        held_next = held_reg;
        if (q_push)
        begin
            pos_next  = in_last ? 2'd0 : pos_upd;
            held_next = in_last ? 4'd0 : held_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            held_reg <= 4'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

endmodule

/* hdl/hbe_queue.sv */
// ----------------------------------------------------------------------------
// hbe_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module hbe_queue
#(
    parameter int DEPTH = hbe_pkg::QUEUE_DEPTH_DEF   // 2 .. 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hbe_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output hbe_pkg::job_t pop_job,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbe_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* hdl/hbe_back.sv */
// ----------------------------------------------------------------------------
// hbe_back
// Plays each job out one character per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module hbe_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          q_pop,
    input  hbe_pkg::job_t q_job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_last
);

    hbe_pkg::job_t job_reg;
    hbe_pkg::job_t job_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          busy_reg;
    logic          busy_next;
    logic          valid_reg;
    logic          valid_next;
    logic [7:0]    char_reg;
    logic [7:0]    char_next;
    logic          last_reg;
    logic          last_next;
    logic          load;
    logic          done;

    // output slot free or being drained this cycle
    assign load  = busy_reg && (!valid_reg || out_ready);
    assign done  = load && (idx_reg == job_reg.last_idx);
    assign q_pop = !q_empty && (!busy_reg || done);

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        job_next   = job_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = job_reg.chars[idx_reg];
            last_next  = job_reg.last && done;
            idx_next   = idx_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
        if (q_pop)
        begin
            job_next  = q_job;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/hbe_checker.sv */
// ----------------------------------------------------------------------------
// hbe_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_base64_text_encoder_unit_defines.svh"

module hbe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled character word stays put
    `HBE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // nothing comes out of reset pending
    `HBE_ASSERT_ALWAYS_NEXT(a_rst_quiet, clk, !rst_n, !m_axis_tvalid, "output valid right after reset")

    // empty queue after reset takes a byte at once
    `HBE_ASSERT_SAME(a_rst_ready, clk, rst_n, $rose(rst_n), s_axis_tready, "input not ready after reset")

endmodule

bind hex_base64_text_encoder_unit hbe_checker u_hbe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
